[design/wsp_pkg.sv]
// Shared types, constants and helpers for the world-to-screen projection block.
package wsp_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned VpWidth = 14;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CoefIdxWidth = 4;
  localparam int unsigned MatDepth = 16;

  localparam logic [VpWidth-1:0] VpWidthReset = 14'd1920;
  localparam logic [VpWidth-1:0] VpHeightReset = 14'd1080;

  localparam logic [CfgIdxWidth-1:0] CfgViewportWidth = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgViewportHeight = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgCameraX = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgCameraY = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgCameraZ = 3'd4;

  localparam logic OpLoad = 1'b0;
  localparam logic OpProject = 1'b1;

  // Datapath step codes issued by the controller.
  typedef enum logic [3:0] {
    DpNone    = 4'd0,
    DpOffset  = 4'd1,
    DpMacInit = 4'd2,
    DpMac     = 4'd3,
    DpMacEnd  = 4'd4,
    DpDivInit = 4'd5,
    DpDivStep = 4'd6,
    DpDivEnd  = 4'd7,
    DpScale   = 4'd8,
    DpResult  = 4'd9
  } dp_op_e;

  typedef struct packed {
    dp_op_e                  op;
    logic [1:0]              col;  // 0 x, 1 y, 2 w
    logic [1:0]              row;  // 0..3 ; row 3 is the constant term
    logic                    axis; // 0 x, 1 y
  } dp_cmd_t;

  typedef struct packed {
    logic w_pos;
    logic div_done;
  } dp_status_t;

  function automatic logic signed [DataWidth-1:0] sat32(input logic signed [95:0] v);
    logic signed [95:0] hi;
    logic signed [95:0] lo;
    hi = 96'sd2147483647;
    lo = -96'sd2147483648;
    if (v > hi) sat32 = 32'sh7fffffff;
    else if (v < lo) sat32 = 32'sh80000000;
    else sat32 = v[DataWidth-1:0];
  endfunction

endpackage

[design/wsp_if.sv]
// Valid/ready channel interfaces for the projection block.
interface wsp_in_if import wsp_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [CoefIdxWidth-1:0]     coef_index;
  logic signed [DataWidth-1:0] coef_value;
  logic signed [DataWidth-1:0] point_x;
  logic signed [DataWidth-1:0] point_y;
  logic signed [DataWidth-1:0] point_z;
  modport source (output valid, operation, coef_index, coef_value, point_x, point_y,
                  point_z, input ready);
  modport sink (input valid, operation, coef_index, coef_value, point_x, point_y,
                point_z, output ready);
endinterface

interface wsp_out_if import wsp_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [DataWidth-1:0] screen_x;
  logic signed [DataWidth-1:0] screen_y;
  logic                        visible;
  modport source (output valid, screen_x, screen_y, visible, input ready);
  modport sink (input valid, screen_x, screen_y, visible, output ready);
endinterface

[design/world_to_screen_projection_core.sv]
// World-to-screen projection core: top level.
// A load item writes its matrix entry on acceptance. A point runs multiply-accumulate
// for three matrix columns, then two bit-serial divides (FracBits+34 steps each, plus
// setup and scaling) on one shared divider, skipped when w is not positive. No new
// item is accepted until the result is in the output register, which waits while an
// earlier result is undrained. Reset (asynchronous, active low) restores viewport
// 1920x1080, camera at zero and the matrix to all zeros through per-entry valid bits.
module world_to_screen_projection_core import wsp_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [DataWidth-1:0]   cfg_data_i,
  wsp_in_if.sink                 in_if,
  wsp_out_if.source              out_if
);
  dp_cmd_t cmd;
  dp_status_t status;
  logic ld_we;

  wsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .in_op_i    (in_if.operation),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .ld_we_o    (ld_we),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  wsp_datapath #(.FracBits(FracBits)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ld_we_i    (ld_we),
    .ld_idx_i   (in_if.coef_index),
    .ld_value_i (in_if.coef_value),
    .point_x_i  (in_if.point_x),
    .point_y_i  (in_if.point_y),
    .point_z_i  (in_if.point_z),
    .screen_x_o (out_if.screen_x),
    .screen_y_o (out_if.screen_y),
    .visible_o  (out_if.visible)
  );
endmodule

[design/wsp_ram.sv]
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module wsp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[design/wsp_datapath.sv]
// Projection datapath: offset, shared multiply-accumulate, restoring divider, scaling.
module wsp_datapath import wsp_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dp_cmd_t                     cmd_i,
  output dp_status_t                  status_o,
  input  logic                        cfg_we_i,
  input  logic [CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [DataWidth-1:0]        cfg_data_i,
  input  logic                        ld_we_i,
  input  logic [CoefIdxWidth-1:0]     ld_idx_i,
  input  logic signed [DataWidth-1:0] ld_value_i,
  input  logic signed [DataWidth-1:0] point_x_i,
  input  logic signed [DataWidth-1:0] point_y_i,
  input  logic signed [DataWidth-1:0] point_z_i,
  output logic signed [DataWidth-1:0] screen_x_o,
  output logic signed [DataWidth-1:0] screen_y_o,
  output logic                        visible_o
);
  localparam int unsigned NumW = DataWidth + 1 + FracBits + 1; // dividend magnitude bits
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [VpWidth-1:0] vp_w_q, vp_h_q;
  logic signed [DataWidth-1:0] cam_q [3];
  logic [MatDepth-1:0] mat_vld_q;
  logic [DataWidth-1:0] ram_rdata;
  logic [CoefIdxWidth-1:0] raddr;
  logic signed [DataWidth-1:0] coef;
  logic signed [DataWidth-1:0] l_q [3];
  logic signed [95:0] acc_q;
  logic signed [DataWidth-1:0] clip_q [3];
  logic signed [63:0] prod;
  logic signed [63:0] fl;
  logic [NumW-1:0] rem_q, quo_q;
  logic [DataWidth:0] den_q;
  logic neg_q;
  logic [CntW-1:0] cnt_q;
  logic signed [DataWidth-1:0] q_q [2];
  logic signed [DataWidth-1:0] sx_q, sy_q;
  logic signed [95:0] num;
  logic [NumW:0] trial;
  logic signed [95:0] qsig;
  logic signed [DataWidth-1:0] qsat;
  logic signed [DataWidth-1:0] scale_q;
  logic signed [63:0] scaled;
  logic signed [DataWidth-1:0] hid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_w_q <= VpWidthReset;
      vp_h_q <= VpHeightReset;
      cam_q[0] <= '0;
      cam_q[1] <= '0;
      cam_q[2] <= '0;
      mat_vld_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgViewportWidth:  vp_w_q <= cfg_data_i[VpWidth-1:0];
          CfgViewportHeight: vp_h_q <= cfg_data_i[VpWidth-1:0];
          CfgCameraX:        cam_q[0] <= cfg_data_i;
          CfgCameraY:        cam_q[1] <= cfg_data_i;
          CfgCameraZ:        cam_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (ld_we_i) mat_vld_q[ld_idx_i] <= 1'b1;
    end
  end

  // Read address: entry (row, column); w uses matrix column 3.
  assign raddr = {cmd_i.row, (cmd_i.col == 2'd2) ? 2'd3 : cmd_i.col};

  wsp_ram #(.Width(DataWidth), .Depth(MatDepth)) u_mat (
    .clk_i  (clk_i),
    .we_i   (ld_we_i),
    .waddr_i(ld_idx_i),
    .wdata_i(ld_value_i),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  logic [CoefIdxWidth-1:0] raddr_q;
  logic [1:0] row_q;
  always_ff @(posedge clk_i) begin
    raddr_q <= raddr;
    row_q <= cmd_i.row;
  end
  assign coef = mat_vld_q[raddr_q] ? ram_rdata : '0;

  // Multiply acts on the coefficient read last cycle (row_q).
  assign prod = 64'(l_q[row_q]) * 64'(coef);
  assign fl = prod >>> FracBits;

  assign num = cmd_i.axis ? (96'(clip_q[2]) + 96'(clip_q[1]))
                          : (96'(clip_q[2]) - 96'(clip_q[0]));
  assign trial = {rem_q, quo_q[NumW-1]} - {1'b0, {(NumW-DataWidth-1){1'b0}}, den_q};
  assign qsig = neg_q ? -96'($signed({1'b0, quo_q})) : 96'($signed({1'b0, quo_q}));
  assign qsat = sat32(qsig);
  assign scaled = 64'(q_q[cmd_i.axis]) * 64'($signed({1'b0, scale_q}));
  assign hid = DataWidth'(-(64'sd100 <<< FracBits));

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DpOffset: begin
        l_q[0] <= sat32(96'(cam_q[0]) - 96'(point_x_i));
        l_q[1] <= sat32(96'(cam_q[1]) - 96'(point_y_i));
        l_q[2] <= sat32(96'(cam_q[2]) - 96'(point_z_i));
      end
      DpMacInit: acc_q <= '0;
      DpMac: acc_q <= acc_q + 96'(fl);
      DpMacEnd: clip_q[cmd_i.col] <= sat32(acc_q + 96'(coef));
      DpDivInit: begin
        neg_q <= num[95];
        quo_q <= NumW'((num[95] ? -num : num) <<< FracBits);
        rem_q <= '0;
        den_q <= {clip_q[2][DataWidth-1:0], 1'b0};
        cnt_q <= CntW'(NumW);
      end
      DpDivStep: begin
        if (!trial[NumW]) rem_q <= trial[NumW-1:0];
        else rem_q <= {rem_q[NumW-2:0], quo_q[NumW-1]};
        quo_q <= {quo_q[NumW-2:0], ~trial[NumW]};
        cnt_q <= cnt_q - 1'b1;
      end
      DpDivEnd: begin
        q_q[cmd_i.axis] <= qsat;
        scale_q <= DataWidth'(cmd_i.axis ? {1'b0, vp_h_q} : {1'b0, vp_w_q});
      end
      DpScale: begin
        if (cmd_i.axis) sy_q <= sat32(96'(scaled));
        else sx_q <= sat32(96'(scaled));
      end
      DpResult: begin
        if (clip_q[2] > 0) begin
          screen_x_o <= sx_q;
          screen_y_o <= sy_q;
          visible_o <= 1'b1;
        end else begin
          screen_x_o <= hid;
          screen_y_o <= hid;
          visible_o <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign status_o.w_pos = clip_q[2] > 0;
  assign status_o.div_done = (cnt_q == CntW'(1));
endmodule

[design/wsp_ctrl.sv]
// Sequencer for the projection block: steps the shared datapath per point.
module wsp_ctrl import wsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       in_op_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       ld_we_o,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);
  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StRead  = 9'b000000010,
    StMac   = 9'b000000100,
    StSum   = 9'b000001000,
    StDInit = 9'b000010000,
    StDiv   = 9'b000100000,
    StDEnd  = 9'b001000000,
    StScale = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] col_q, col_d, row_q, row_d;
  logic axis_q, axis_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  // The output register holds a waiting result; StOut stalls until it drains.
  assign in_ready_o = (state_q == StIdle);
  assign accept = in_valid_i && in_ready_o;
  assign ld_we_o = accept && (in_op_i == OpLoad);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    col_d = col_q;
    row_d = row_q;
    axis_d = axis_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o = '{op: DpNone, col: col_q, row: row_q, axis: axis_q};
    case (state_q)
      StIdle: begin
        if (accept && in_op_i == OpProject) begin
          cmd_o.op = DpOffset;
          cmd_o.row = 2'd0;
          cmd_o.col = 2'd0;
          col_d = 2'd0;
          row_d = 2'd0;
          state_d = StRead;
        end
      end
      StRead: begin
        // Issue read of row 0 and clear the accumulator.
        cmd_o.op = DpMacInit;
        row_d = 2'd1;
        state_d = StMac;
      end
      StMac: begin
        cmd_o.op = DpMac;
        if (row_q == 2'd3) state_d = StSum;
        row_d = row_q + 2'd1;
      end
      StSum: begin
        cmd_o.op = DpMacEnd;
        row_d = 2'd0;
        if (col_q == 2'd2) begin
          axis_d = 1'b0;
          state_d = StDInit;
        end else begin
          col_d = col_q + 2'd1;
          state_d = StRead;
        end
      end
      StDInit: begin
        if (status_i.w_pos) begin
          cmd_o.op = DpDivInit;
          state_d = StDiv;
        end else begin
          state_d = StOut;
        end
      end
      StDiv: begin
        cmd_o.op = DpDivStep;
        if (status_i.div_done) state_d = StDEnd;
      end
      StDEnd: begin
        cmd_o.op = DpDivEnd;
        state_d = StScale;
      end
      StScale: begin
        cmd_o.op = DpScale;
        if (axis_q) state_d = StOut;
        else begin
          axis_d = 1'b1;
          state_d = StDInit;
        end
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = DpResult;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      col_q <= '0;
      row_q <= '0;
      axis_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q <= col_d;
      row_q <= row_d;
      axis_q <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == StIdle) else $error("ready outside idle");
  a_result_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StOut) else $error("result without sequence");
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
endmodule

[bench/tb_world_to_screen_projection_core.sv]
// Testbench for the world-to-screen projection core: driver, predictor, checker.
`timescale 1ns / 1ps
module tb_world_to_screen_projection_core;
  import wsp_pkg::*;

  localparam int FracBits = 16;

  typedef struct {
    logic                  operation;
    logic [3:0]            coef_index;
    logic signed [31:0]    coef_value;
    logic signed [31:0]    point_x;
    logic signed [31:0]    point_y;
    logic signed [31:0]    point_z;
  } request_t;

  typedef struct {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               visible;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [DataWidth-1:0] cfg_data_i = '0;

  wsp_in_if in_ch ();
  wsp_out_if out_ch ();

  world_to_screen_projection_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  always #4 clk_i = ~clk_i;

  request_t pending_q[$];
  pixel_t   pixel_q[$];
  int       errors = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       hold_cycles = 0;
  bit       drive_en = 1'b0;

  // Predictor state.
  longint mat[16];
  longint vp_w, vp_h, cam_x, cam_y, cam_z;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clip_sum(longint lx, longint ly, longint lz, int col);
    longint acc;
    longint l[3];
    acc = mat[12 + col];
    l[0] = lx; l[1] = ly; l[2] = lz;
    for (int r = 0; r < 3; r++)
      acc += (l[r] * mat[r * 4 + col]) >>> FracBits;  // arithmetic shift = floor
    return clamp32(acc);
  endfunction

  function automatic pixel_t project_point(request_t rq);
    pixel_t p;
    longint lx, ly, lz, cx, cy, cw, qx, qy;
    lx = clamp32(cam_x - longint'(rq.point_x));
    ly = clamp32(cam_y - longint'(rq.point_y));
    lz = clamp32(cam_z - longint'(rq.point_z));
    cx = clip_sum(lx, ly, lz, 0);
    cy = clip_sum(lx, ly, lz, 1);
    cw = clip_sum(lx, ly, lz, 3);
    if (cw <= 0) begin
      p.screen_x = -32'sd100 <<< FracBits;
      p.screen_y = -32'sd100 <<< FracBits;
      p.visible = 1'b0;
    end else begin
      qx = clamp32(((cw - cx) <<< FracBits) / (2 * cw));
      qy = clamp32(((cw + cy) <<< FracBits) / (2 * cw));
      p.screen_x = 32'(clamp32(qx * vp_w));
      p.screen_y = 32'(clamp32(qy * vp_h));
      p.visible = 1'b1;
    end
    return p;
  endfunction

  // Driver.
  always @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      if (in_ch.operation == OpLoad) mat[in_ch.coef_index] = longint'(in_ch.coef_value);
      else pixel_q.push_back(project_point('{in_ch.operation, in_ch.coef_index,
          in_ch.coef_value, in_ch.point_x, in_ch.point_y, in_ch.point_z}));
    end
    if ((!in_ch.valid || in_ch.ready) && rst_ni) begin
      if (drive_en && pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        request_t rq;
        rq = pending_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.operation <= rq.operation;
        in_ch.coef_index <= rq.coef_index;
        in_ch.coef_value <= rq.coef_value;
        in_ch.point_x <= rq.point_x;
        in_ch.point_y <= rq.point_y;
        in_ch.point_z <= rq.point_z;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall.
  always @(posedge clk_i) begin
    if (out_ch.valid && out_ch.ready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected result x=%0d y=%0d", out_ch.screen_x, out_ch.screen_y);
        errors++;
      end else begin
        pixel_t e;
        e = pixel_q.pop_front();
        if (out_ch.screen_x !== e.screen_x) begin
          $error("screen_x expected %0d actual %0d", e.screen_x, out_ch.screen_x);
          errors++;
        end
        if (out_ch.screen_y !== e.screen_y) begin
          $error("screen_y expected %0d actual %0d", e.screen_y, out_ch.screen_y);
          errors++;
        end
        if (out_ch.visible !== e.visible) begin
          $error("visible expected %0b actual %0b", e.visible, out_ch.visible);
          errors++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OpLoad;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(8'hff)) << 16) >>> 8;
      3: return $signed($urandom_range(32'h3ffff)) - 32'sh20000;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic push_load(int idx, logic signed [31:0] v);
    request_t rq;
    rq = '{OpLoad, idx[3:0], v, $signed($urandom()), $signed($urandom()),
           $signed($urandom())};
    pending_q.push_back(rq);
  endtask

  task automatic push_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
    request_t rq;
    rq = '{OpProject, 4'($urandom()), $signed($urandom()), x, y, z};
    pending_q.push_back(rq);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgViewportWidth:  vp_w = longint'(v[13:0]);
      CfgViewportHeight: vp_h = longint'(v[13:0]);
      CfgCameraX:        cam_x = longint'($signed(v));
      CfgCameraY:        cam_y = longint'($signed(v));
      CfgCameraZ:        cam_z = longint'($signed(v));
      default: ;
    endcase
  endtask

  // Run queued items and wait until the block has drained.
  task automatic run_phase();
    drive_en = 1'b1;
    wait (pending_q.size() == 0);
    @(posedge clk_i);
    while (in_ch.valid) @(posedge clk_i);
    wait (pixel_q.size() == 0);
    drive_en = 1'b0;
    repeat (200) @(posedge clk_i);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 12) push_load($urandom_range(15), rand_val());
      else push_point(rand_val(), rand_val(), rand_val());
    end
  endtask

  // Load a sensible matrix with a positive w column.
  task automatic load_sane_matrix();
    for (int i = 0; i < 16; i++)
      push_load(i, ((i % 4) == 3) ? 32'sh00010000 + $urandom_range(32'h3ffff)
                                  : $signed($urandom_range(32'h3ffff)) - 32'sh20000);
  endtask

  initial begin
    vp_w = 1920; vp_h = 1080; cam_x = 0; cam_y = 0; cam_z = 0;
    foreach (mat[i]) mat[i] = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: zero matrix hides everything, then extremes.
    send_idle_pct = 7; recv_idle_pct = 64;
    push_point(0, 0, 0);
    push_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    load_sane_matrix();
    push_point(0, 0, 0);
    push_point(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    push_point(32'sh00010000, -32'sh00010000, 32'sh00020000);
    push_load(15, 32'sh7fffffff);
    push_load(3, 32'sh80000000);
    push_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    push_load(15, 32'sh00000001);
    push_point(0, 0, 0);
    run_phase();

    write_reg(CfgViewportWidth, 32'd0);
    write_reg(CfgViewportHeight, 32'h3fff);
    write_reg(CfgCameraX, 32'h7fffffff);
    write_reg(CfgCameraY, 32'h80000000);
    write_reg(CfgCameraZ, 32'h00050000);
    write_reg(3'd7, 32'hffffffff);
    load_sane_matrix();
    random_phase(300);
    run_phase();

    send_idle_pct = 64; recv_idle_pct = 7;
    write_reg(CfgViewportWidth, 32'd8192);
    write_reg(CfgViewportHeight, 32'd0);
    write_reg(CfgCameraX, 32'h0);
    write_reg(CfgCameraY, 32'h0);
    write_reg(CfgCameraZ, 32'hfffb0000);
    load_sane_matrix();
    random_phase(300);
    run_phase();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(CfgViewportWidth, 32'd1);
    write_reg(CfgViewportHeight, 32'd1);
    write_reg(CfgCameraX, $urandom());
    write_reg(CfgCameraY, $urandom());
    write_reg(CfgCameraZ, $urandom());
    load_sane_matrix();
    random_phase(300);
    hold_cycles = 3000;
    run_phase();

    write_reg(CfgViewportWidth, 32'd1920);
    write_reg(CfgViewportHeight, 32'd1080);
    load_sane_matrix();
    random_phase(250);
    run_phase();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
